[sv/ctc_pkg.sv]
// package: types, codes and reset constants of the comparator threshold calibrator
`timescale 1ns / 1ps

package ctc_pkg;

    localparam int LEVEL_BITS_DEF = 12;
    localparam int COUNT_BITS_DEF = 7;
    localparam int CFG_INDEX_BITS = 3;

    localparam int SWEEP_START_RST    = 2200;
    localparam int SWEEP_FLOOR_RST    = 1800;
    localparam int FALLBACK_LEVEL_RST = 2048;
    localparam int VERIFY_SAMPLES_RST = 100;
    localparam int PASS_THRESHOLD_RST = 80;
    localparam int VALID_LOW_RST      = 2000;
    localparam int VALID_HIGH_RST     = 2120;
    localparam int LEVEL_RST          = 2048;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SWEEP  = 2'd1,
        PH_VERIFY = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic {
        OP_START  = 1'b0,
        OP_SAMPLE = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SWEEP_START    = 3'd0,
        CFG_SWEEP_FLOOR    = 3'd1,
        CFG_FALLBACK_LEVEL = 3'd2,
        CFG_VERIFY_SAMPLES = 3'd3,
        CFG_PASS_THRESHOLD = 3'd4,
        CFG_VALID_LOW      = 3'd5,
        CFG_VALID_HIGH     = 3'd6
    } cfg_reg_t;

endpackage

[sv/ctc_if.sv]
// interfaces: sample and result channels with valid/ready handshake
`timescale 1ns / 1ps

interface ctc_sample_if;
    logic valid;
    logic ready;
    logic opcode;
    logic trip;

    modport source (output valid, output opcode, output trip, input ready);
    modport sink (input valid, input opcode, input trip, output ready);
endinterface

interface ctc_result_if #(
    parameter int LEVEL_BITS = ctc_pkg::LEVEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] level;
    logic [1:0]            phase;
    logic                  found;
    logic                  in_range;

    modport source (output valid, output level, output phase, output found,
                    output in_range, input ready);
    modport sink (input valid, input level, input phase, input found,
                  input in_range, output ready);
endinterface

[sv/ctc_step.sv]
// next-state logic: one calibration step per sample or start item
`timescale 1ns / 1ps

module ctc_step #(
    parameter int LEVEL_BITS = ctc_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS = ctc_pkg::COUNT_BITS_DEF
) (
    input  logic                  opcode,
    input  logic                  trip,
    input  ctc_pkg::phase_t       phase,
    input  logic [LEVEL_BITS-1:0] level,
    input  logic [COUNT_BITS-1:0] samples,
    input  logic [COUNT_BITS-1:0] trips,
    input  logic                  found,
    input  logic [LEVEL_BITS-1:0] sweep_start,
    input  logic [LEVEL_BITS-1:0] sweep_floor,
    input  logic [LEVEL_BITS-1:0] fallback_level,
    input  logic [COUNT_BITS-1:0] verify_samples,
    input  logic [COUNT_BITS-1:0] pass_threshold,
    input  logic [LEVEL_BITS-1:0] valid_low,
    input  logic [LEVEL_BITS-1:0] valid_high,
    output ctc_pkg::phase_t       phase_next,
    output logic [LEVEL_BITS-1:0] level_next,
    output logic [COUNT_BITS-1:0] samples_next,
    output logic [COUNT_BITS-1:0] trips_next,
    output logic                  found_next,
    output logic                  in_range
);
    import ctc_pkg::*;

    logic [LEVEL_BITS-1:0] level_dec;
    logic [COUNT_BITS-1:0] samples_inc;
    logic [COUNT_BITS-1:0] trips_inc;
    logic [COUNT_BITS-1:0] need;
    logic                  at_floor;

    assign level_dec   = level - LEVEL_BITS'(1);
    assign samples_inc = samples + COUNT_BITS'(1);
    assign trips_inc   = trips + COUNT_BITS'(trip);
    assign need        = (verify_samples == '0) ? COUNT_BITS'(1) : verify_samples;
    assign at_floor    = (level_dec <= sweep_floor);

    always_comb
    begin
        phase_next   = phase;
        level_next   = level;
        samples_next = samples;
        trips_next   = trips;
        found_next   = found;
        if (opcode == OP_START)
        begin
            samples_next = '0;
            trips_next   = '0;
            found_next   = 1'b0;
            if (sweep_start <= sweep_floor)
            begin
                level_next = fallback_level;
                phase_next = PH_DONE;
            end
            else
            begin
                level_next = sweep_start;
                phase_next = PH_SWEEP;
            end
        end
        else
        begin
            case (phase)
                PH_SWEEP:
                begin
                    if (trip)
                    begin
                        samples_next = '0;
                        trips_next   = '0;
                        phase_next   = PH_VERIFY;
                    end
                    else if (at_floor)
                    begin
                        level_next = fallback_level;
                        found_next = 1'b0;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        level_next = level_dec;
                    end
                end
                PH_VERIFY:
                begin
                    samples_next = samples_inc;
                    trips_next   = trips_inc;
                    if (samples_inc >= need)
                    begin
                        if (trips_inc >= pass_threshold)
                        begin
                            found_next = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (at_floor)
                        begin
                            level_next = fallback_level;
                            found_next = 1'b0;
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            level_next = level_dec;
                            phase_next = PH_SWEEP;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase;
                end
            endcase
        end
    end

    assign in_range = (level_next >= valid_low) && (level_next <= valid_high);

endmodule

[sv/comparator_threshold_calibrator_unit.sv]
// top level: comparator threshold calibration sequencer with config registers
`timescale 1ns / 1ps
// a sample transfer's result is registered and shows on the result channel in the cycle after the transfer
// throughput: one item per cycle while results are taken, with combinational step logic and a result register
// a waiting result holds the sample side until it is taken, a new transfer can enter
// on the same edge the waiting result leaves
// reset: config registers take their default levels, phase idle, level 2048,
// counters and found flag cleared, no result pending

module comparator_threshold_calibrator_unit #(
    parameter int LEVEL_BITS = ctc_pkg::LEVEL_BITS_DEF,
    parameter int COUNT_BITS = ctc_pkg::COUNT_BITS_DEF,
    parameter int CFG_BITS   = (LEVEL_BITS > COUNT_BITS) ? LEVEL_BITS : COUNT_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ctc_sample_if.sink                         sample_ch,
    ctc_result_if.source                       result_ch,
    input  logic                               cfg_we,
    input  logic [ctc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                cfg_data
);
    import ctc_pkg::*;

    logic [LEVEL_BITS-1:0] sweep_start_reg;
    logic [LEVEL_BITS-1:0] sweep_floor_reg;
    logic [LEVEL_BITS-1:0] fallback_level_reg;
    logic [COUNT_BITS-1:0] verify_samples_reg;
    logic [COUNT_BITS-1:0] pass_threshold_reg;
    logic [LEVEL_BITS-1:0] valid_low_reg;
    logic [LEVEL_BITS-1:0] valid_high_reg;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [LEVEL_BITS-1:0] level_reg;
    logic [LEVEL_BITS-1:0] level_next;
    logic [COUNT_BITS-1:0] samples_reg;
    logic [COUNT_BITS-1:0] samples_next;
    logic [COUNT_BITS-1:0] trips_reg;
    logic [COUNT_BITS-1:0] trips_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  in_range_next;

    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] out_level_reg;
    logic [1:0]            out_phase_reg;
    logic                  out_found_reg;
    logic                  out_in_range_reg;

    logic                  accept;

    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept          = sample_ch.valid && sample_ch.ready;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_start_reg    <= LEVEL_BITS'(SWEEP_START_RST);
            sweep_floor_reg    <= LEVEL_BITS'(SWEEP_FLOOR_RST);
            fallback_level_reg <= LEVEL_BITS'(FALLBACK_LEVEL_RST);
            verify_samples_reg <= COUNT_BITS'(VERIFY_SAMPLES_RST);
            pass_threshold_reg <= COUNT_BITS'(PASS_THRESHOLD_RST);
            valid_low_reg      <= LEVEL_BITS'(VALID_LOW_RST);
            valid_high_reg     <= LEVEL_BITS'(VALID_HIGH_RST);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SWEEP_START:    sweep_start_reg    <= cfg_data[LEVEL_BITS-1:0];
                CFG_SWEEP_FLOOR:    sweep_floor_reg    <= cfg_data[LEVEL_BITS-1:0];
                CFG_FALLBACK_LEVEL: fallback_level_reg <= cfg_data[LEVEL_BITS-1:0];
                CFG_VERIFY_SAMPLES: verify_samples_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_PASS_THRESHOLD: pass_threshold_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_VALID_LOW:      valid_low_reg      <= cfg_data[LEVEL_BITS-1:0];
                CFG_VALID_HIGH:     valid_high_reg     <= cfg_data[LEVEL_BITS-1:0];
                default:            ;
            endcase
        end
    end

    ctc_step #(
        .LEVEL_BITS (LEVEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .opcode         (sample_ch.opcode),
        .trip           (sample_ch.trip),
        .phase          (phase_reg),
        .level          (level_reg),
        .samples        (samples_reg),
        .trips          (trips_reg),
        .found          (found_reg),
        .sweep_start    (sweep_start_reg),
        .sweep_floor    (sweep_floor_reg),
        .fallback_level (fallback_level_reg),
        .verify_samples (verify_samples_reg),
        .pass_threshold (pass_threshold_reg),
        .valid_low      (valid_low_reg),
        .valid_high     (valid_high_reg),
        .phase_next     (phase_next),
        .level_next     (level_next),
        .samples_next   (samples_next),
        .trips_next     (trips_next),
        .found_next     (found_next),
        .in_range       (in_range_next)
    );

    // calibration state, updated once per transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            level_reg   <= LEVEL_BITS'(LEVEL_RST);
            samples_reg <= '0;
            trips_reg   <= '0;
            found_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            level_reg   <= level_next;
            samples_reg <= samples_next;
            trips_reg   <= trips_next;
            found_reg   <= found_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_level_reg    <= level_next;
            out_phase_reg    <= phase_next;
            out_found_reg    <= found_next;
            out_in_range_reg <= in_range_next;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.level    = out_level_reg;
    assign result_ch.phase    = out_phase_reg;
    assign result_ch.found    = out_found_reg;
    assign result_ch.in_range = out_in_range_reg;

endmodule

[verif/tb_comparator_threshold_calibrator_unit.sv]
// testbench: directed and random calibration runs with random stalls, checked by a scoreboard
`timescale 1ns / 1ps

module tb_comparator_threshold_calibrator_unit;

    import ctc_pkg::*;

    localparam int ITEM_TARGET   = 1200;
    localparam int HOLD_CYCLES   = 250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LEVEL_MAX     = 4095;

    typedef struct packed {
        logic [11:0] level;
        phase_t      phase;
        logic        found;
        logic        in_range;
    } calib_result_t;

    class calib_scoreboard;
        logic [11:0]   start_lvl;
        logic [11:0]   floor_lvl;
        logic [11:0]   fallback_lvl;
        logic [6:0]    verify_cnt;
        logic [6:0]    pass_cnt;
        logic [11:0]   win_low;
        logic [11:0]   win_high;
        phase_t        ph;
        logic [11:0]   lvl;
        logic [6:0]    samples;
        logic [6:0]    trips;
        logic          found_flag;
        calib_result_t expected_q[$];
        int            errors;
        int            accepted;

        function new();
            start_lvl    = 12'(SWEEP_START_RST);
            floor_lvl    = 12'(SWEEP_FLOOR_RST);
            fallback_lvl = 12'(FALLBACK_LEVEL_RST);
            verify_cnt   = 7'(VERIFY_SAMPLES_RST);
            pass_cnt     = 7'(PASS_THRESHOLD_RST);
            win_low      = 12'(VALID_LOW_RST);
            win_high     = 12'(VALID_HIGH_RST);
            ph           = PH_IDLE;
            lvl          = 12'(LEVEL_RST);
            samples      = '0;
            trips        = '0;
            found_flag   = 1'b0;
            errors       = 0;
            accepted     = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [11:0] v);
            case (idx)
                CFG_SWEEP_START:    start_lvl = v;
                CFG_SWEEP_FLOOR:    floor_lvl = v;
                CFG_FALLBACK_LEVEL: fallback_lvl = v;
                CFG_VERIFY_SAMPLES: verify_cnt = v[6:0];
                CFG_PASS_THRESHOLD: pass_cnt = v[6:0];
                CFG_VALID_LOW:      win_low = v;
                CFG_VALID_HIGH:     win_high = v;
                default: ;
            endcase
        endfunction

        function void level_down();
            lvl = lvl - 12'd1;
            if (lvl <= floor_lvl)
            begin
                lvl        = fallback_lvl;
                found_flag = 1'b0;
                ph         = PH_DONE;
            end
            else
            begin
                ph = PH_SWEEP;
            end
        endfunction

        function void note_sample(opcode_t op, logic trip_bit);
            logic [6:0]    need;
            calib_result_t r;
            accepted++;
            if (op == OP_START)
            begin
                lvl        = start_lvl;
                samples    = '0;
                trips      = '0;
                found_flag = 1'b0;
                if (lvl <= floor_lvl)
                begin
                    lvl = fallback_lvl;
                    ph  = PH_DONE;
                end
                else
                begin
                    ph = PH_SWEEP;
                end
            end
            else if (ph == PH_SWEEP)
            begin
                if (trip_bit)
                begin
                    samples = '0;
                    trips   = '0;
                    ph      = PH_VERIFY;
                end
                else
                begin
                    level_down();
                end
            end
            else if (ph == PH_VERIFY)
            begin
                need    = (verify_cnt == 7'd0) ? 7'd1 : verify_cnt;
                samples = samples + 7'd1;
                trips   = trips + {6'd0, trip_bit};
                if (samples >= need)
                begin
                    if (trips >= pass_cnt)
                    begin
                        found_flag = 1'b1;
                        ph         = PH_DONE;
                    end
                    else
                    begin
                        level_down();
                    end
                end
            end
            r.level    = lvl;
            r.phase    = ph;
            r.found    = found_flag;
            r.in_range = (lvl >= win_low) && (lvl <= win_high);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [11:0] level, logic [1:0] phase, logic found,
                                   logic in_range);
            calib_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual level %0d phase %0d",
                         $time, level, phase);
                return;
            end
            e = expected_q.pop_front();
            if (level !== e.level)
            begin
                errors++;
                $display("%0t: level mismatch, expected %0d actual %0d", $time, e.level, level);
            end
            if (phase !== e.phase)
            begin
                errors++;
                $display("%0t: phase mismatch, expected %0d actual %0d", $time, e.phase, phase);
            end
            if (found !== e.found)
            begin
                errors++;
                $display("%0t: found mismatch, expected %0b actual %0b", $time, e.found, found);
            end
            if (in_range !== e.in_range)
            begin
                errors++;
                $display("%0t: in_range mismatch, expected %0b actual %0b",
                         $time, e.in_range, in_range);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    logic [11:0] cfg_data;

    bit          quiet;
    bit          hold_request;
    int          idle_cycles = 0;

    calib_scoreboard sb = new();

    ctc_sample_if sample_ch ();
    ctc_result_if #(.LEVEL_BITS(12)) result_ch ();

    comparator_threshold_calibrator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // transfer monitor and idle counter
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(opcode_t'(sample_ch.opcode), sample_ch.trip);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.level, result_ch.phase, result_ch.found,
                                result_ch.in_range);
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // result side
    initial
    begin
        int stall;
        result_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            stall = quiet ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
        end
    end

    task automatic send_item(opcode_t op, logic trip_bit);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.opcode <= op;
        sample_ch.trip   <= trip_bit;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic settle();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_reg(cfg_reg_t idx, logic [11:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.write_reg(idx, v);
    endtask

    task automatic load_config(logic [11:0] s, logic [11:0] f, logic [11:0] fb,
                               logic [6:0] vs, logic [6:0] pt,
                               logic [11:0] lo, logic [11:0] hi);
        set_reg(CFG_SWEEP_START, s);
        set_reg(CFG_SWEEP_FLOOR, f);
        set_reg(CFG_FALLBACK_LEVEL, fb);
        set_reg(CFG_VERIFY_SAMPLES, {5'd0, vs});
        set_reg(CFG_PASS_THRESHOLD, {5'd0, pt});
        set_reg(CFG_VALID_LOW, lo);
        set_reg(CFG_VALID_HIGH, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(bit with_hold);
        int si;
        int fi;
        int span;
        int lo;
        int hi;
        int vs;
        int pt;
        int pr;
        int n;
        int m_lvl;
        int m_cnt;
        int m_win;
        settle();
        m_lvl = $urandom_range(0, 4);
        m_cnt = $urandom_range(0, 5);
        m_win = $urandom_range(0, 3);
        span  = $urandom_range(0, 40);
        si    = $urandom_range(0, LEVEL_MAX);
        if (m_lvl == 0)
            si = LEVEL_MAX;
        else if (m_lvl == 1)
            si = $urandom_range(0, 40);
        fi = (si >= span) ? si - span : 0;
        if (m_lvl == 2)
            fi = $urandom_range(0, LEVEL_MAX);
        vs = $urandom_range(1, 10);
        if (m_cnt == 0)
            vs = 127;
        else if (m_cnt == 1)
            vs = 0;
        pt = $urandom_range(0, vs + 1);
        if (pt > 127)
            pt = 127;
        if (m_cnt == 2)
            pt = 127;
        else if (m_cnt == 3)
            pt = 0;
        lo = fi + $urandom_range(0, span);
        hi = lo + $urandom_range(0, 20);
        if (m_win == 0)
        begin
            lo = $urandom_range(0, LEVEL_MAX);
            hi = $urandom_range(0, LEVEL_MAX);
        end
        else if (m_win == 1)
        begin
            lo = 0;
            hi = LEVEL_MAX;
        end
        if (lo > LEVEL_MAX)
            lo = LEVEL_MAX;
        if (hi > LEVEL_MAX)
            hi = LEVEL_MAX;
        load_config(12'(si), 12'(fi), 12'($urandom_range(0, LEVEL_MAX)), 7'(vs), 7'(pt),
                    12'(lo), 12'(hi));
        quiet = ($urandom_range(0, 3) == 0);
        if (with_hold)
            hold_request = 1'b1;
        // stray samples ahead of the first start
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) send_item(OP_SAMPLE, 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 6))
        begin
            send_item(OP_START, 1'($urandom_range(0, 1)));
            pr = $urandom_range(0, 100);
            n  = $urandom_range(3, 40 + vs);
            repeat (n) send_item(OP_SAMPLE, $urandom_range(0, 99) < pr);
        end
    endtask

    initial
    begin
        int phase_no;
        sample_ch.valid  <= 1'b0;
        sample_ch.opcode <= OP_START;
        sample_ch.trip   <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_SWEEP_START;
        cfg_data         <= '0;
        quiet            = 1'b0;
        hold_request     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // samples while idle, restart during verify
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_START, 1'b1);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_START, 1'b0);

        // top levels, floor fallback, zero sample count, zero threshold
        settle();
        load_config(12'd4095, 12'd4093, 12'd0, 7'd0, 7'd0, 12'd4095, 12'd4095);
        send_item(OP_START, 1'b0);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_START, 1'b0);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_SAMPLE, 1'b0);

        // start at the floor, inverted window
        settle();
        load_config(12'd0, 12'd0, 12'd4095, 7'd2, 7'd2, 12'd4095, 12'd0);
        send_item(OP_START, 1'b1);

        // failed verify resumes one lower, then passes
        settle();
        load_config(12'd2, 12'd0, 12'd0, 7'd2, 7'd2, 12'd0, 12'd4095);
        send_item(OP_START, 1'b0);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b0);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b1);
        send_item(OP_SAMPLE, 1'b1);

        phase_no = 0;
        while (sb.accepted < ITEM_TARGET)
        begin
            random_phase(phase_no == 0);
            phase_no++;
        end

        settle();
        repeat (5) @(posedge clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
